### hw/rtl/sks_pkg.sv
// Package for the sorted unique key set: transfer payload structs, mode and
// status codes, and the command/status structs between controller and datapath.
// No dependencies.
package sks_pkg;

  localparam int MAX_RESULTS = 16;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_COUNT  = 2'd2,
    MODE_LIST   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_PRESENT     = 3'd1,
    ST_NOT_PRESENT = 3'd2,
    ST_FULL        = 3'd3,
    ST_EMPTY       = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] key_head;
    logic [7:0]  key_tail;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] entry_head;
    logic [7:0]  entry_tail;
    logic [4:0]  entry_count;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic    capture;
    logic    apply_ins;
    logic    apply_rem;
    logic    emit;
    logic    emit_entry;
    logic    emit_last;
    status_t emit_status;
    logic    list_start;
    logic    list_step;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic full;
    logic empty;
    logic list_last;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/sks_ctrl.sv
// Controller for the sorted unique key set: sequences accept, execute and list.
// Depends on sks_pkg for mode, status and command/status structs.
module sks_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  logic [1:0]    req_mode,
  input  sks_pkg::sts_t sts,
  output sks_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LIST
  } state_t;

  state_t        state, state_next;
  sks_pkg::mode_t mode, mode_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.emit_status = sks_pkg::ST_OK;
    state_next = state;
    mode_next = mode;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          mode_next = sks_pkg::mode_t'(req_mode);
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
          cmd.emit = 1'b1;
          cmd.emit_last = 1'b1;
          case (mode)
            sks_pkg::MODE_INSERT: begin
              if (sts.hit) begin
                cmd.emit_status = sks_pkg::ST_PRESENT;
              end else if (sts.full) begin
                cmd.emit_status = sks_pkg::ST_FULL;
              end else begin
                cmd.apply_ins = 1'b1;
              end
            end
            sks_pkg::MODE_REMOVE: begin
              if (sts.hit) begin
                cmd.apply_rem = 1'b1;
              end else begin
                cmd.emit_status = sks_pkg::ST_NOT_PRESENT;
              end
            end
            sks_pkg::MODE_COUNT: begin
              cmd.emit_status = sks_pkg::ST_OK;
            end
            sks_pkg::MODE_LIST: begin
              if (sts.empty) begin
                cmd.emit_status = sks_pkg::ST_EMPTY;
              end else begin
                cmd.emit = 1'b0;
                cmd.emit_last = 1'b0;
                cmd.list_start = 1'b1;
                state_next = S_LIST;
              end
            end
            default: begin
              cmd.emit_status = sks_pkg::ST_OK;
            end
          endcase
        end
      end
      S_LIST: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_entry = 1'b1;
          cmd.list_step = 1'b1;
          cmd.emit_last = sts.list_last;
          if (sts.list_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode <= sks_pkg::MODE_INSERT;
    end else begin
      state <= state_next;
      mode <= mode_next;
    end
  end

endmodule

### hw/rtl/sks_dp.sv
// Datapath for the sorted unique key set: row of compare-and-shift cells,
// entry count, list pointer and result register. Depends on sks_pkg.
module sks_dp #(
  parameter int CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  sks_pkg::req_t req,
  input  sks_pkg::cmd_t cmd,
  output sks_pkg::sts_t sts,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sks_pkg::rsp_t rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

  logic [71:0]      cells [CAPACITY];
  logic [71:0]      key;
  logic [CAPACITY-1:0] lt, eq, lt_now, eq_now;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx;
  logic [CMP_W-1:0] idx_inc, lim;
  logic [CNT_W+4:0] count_ext;
  logic [71:0]      sel;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt_now[i] = (CNT_W'(i) < count) && (cells[i] < {req.key_head, req.key_tail});
      eq_now[i] = (CNT_W'(i) < count) && (cells[i] == {req.key_head, req.key_tail});
    end
  end

  assign idx_inc = CMP_W'(idx) + CMP_W'(1);
  assign lim = (CMP_W'(count) < CMP_W'(sks_pkg::MAX_RESULTS)) ?
               CMP_W'(count) : CMP_W'(sks_pkg::MAX_RESULTS);

  assign sts.hit = |eq;
  assign sts.full = (count == CNT_W'(CAPACITY));
  assign sts.empty = (count == '0);
  assign sts.list_last = (idx_inc == lim);
  assign sts.out_free = !rsp_valid || !rsp_stall;

  always_comb begin
    count_next = count;
    if (cmd.apply_ins) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.apply_rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  assign count_ext = {5'd0, count_next};
  assign sel = cells[idx[IDX_W-1:0]];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [71:0] ins_val, rem_val;
    if (g == 0) begin : g_first
      assign ins_val = key;
    end else begin : g_rest
      assign ins_val = lt[g-1] ? key : cells[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign rem_val = cells[g];
    end else begin : g_mid
      assign rem_val = cells[g+1];
    end
    always_ff @(posedge clk) begin
      if (cmd.apply_ins && !lt[g]) begin
        cells[g] <= ins_val;
      end else if (cmd.apply_rem && !lt[g]) begin
        cells[g] <= rem_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key <= {req.key_head, req.key_tail};
      lt <= lt_now;
      eq <= eq_now;
    end
    if (cmd.emit) begin
      rsp.status <= cmd.emit_status;
      rsp.entry_head <= cmd.emit_entry ? sel[71:8] : 64'd0;
      rsp.entry_tail <= cmd.emit_entry ? sel[7:0] : 8'd0;
      rsp.entry_count <= count_ext[4:0];
      rsp.last <= cmd.emit_last;
    end
    if (cmd.list_start) begin
      idx <= '0;
    end else if (cmd.list_step) begin
      idx <= idx + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/sorted_unique_key_set.sv
// Top level of the sorted unique key set: controller plus cell datapath.
// Depends on sks_pkg, sks_ctrl and sks_dp.
//
//   channel  handshake             payload               direction
//   req      req_valid/req_stall   req (mode, key)       in
//   rsp      rsp_valid/rsp_stall   rsp (status, entry)   out
//
// Insert, remove and count: all cells compare in the accept cycle; then,
// with rsp free, cells >= the key shift together and the result registers.
// List: start step, then one entry per unstalled cycle, up to 16 entries.
// A result waiting under rsp_stall holds the controller; req is taken only
// in idle. Synchronous reset empties the set; cells need no clearing.
module sorted_unique_key_set #(
  parameter int CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sks_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sks_pkg::rsp_t rsp
);

  sks_pkg::cmd_t cmd;
  sks_pkg::sts_t sts;

  sks_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_mode  (req.mode),
    .sts       (sts),
    .cmd       (cmd)
  );

  sks_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

### verif/sks_result_checker.sv
// Result checker for the sorted unique key set: watches the req and rsp
// transfers, keeps its own sorted copy of the set and compares every result.
// Depends on sks_pkg.
module sks_result_checker #(
  parameter int CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  sks_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  sks_pkg::rsp_t rsp,
  output int            fails,
  output int            pending,
  output int            checked,
  output int            full_rejects,
  output int            longest_list
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [71:0]   set_keys [CAPACITY];
  int            set_size;
  sks_pkg::rsp_t expected_q [$];

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  task automatic compare_result(input sks_pkg::rsp_t got);
    sks_pkg::rsp_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %0h", $time, got);
      fails++;
    end else begin
      want = expected_q.pop_front();
      check_field("status", 64'(want.status), 64'(got.status));
      check_field("entry_head", want.entry_head, got.entry_head);
      check_field("entry_tail", 64'(want.entry_tail), 64'(got.entry_tail));
      check_field("entry_count", 64'(want.entry_count), 64'(got.entry_count));
      check_field("last", 64'(want.last), 64'(got.last));
      checked++;
    end
  endtask

  task automatic apply_request(input sks_pkg::req_t r);
    logic [71:0]   k;
    int            pos;
    int            i;
    int            n;
    logic          hit;
    sks_pkg::rsp_t e;
    k = {r.key_head, r.key_tail};
    pos = 0;
    while (pos < set_size && set_keys[pos] < k) pos++;
    hit = (pos < set_size) && (set_keys[pos] == k);
    e = '0;
    e.last = 1'b1;
    case (sks_pkg::mode_t'(r.mode))
      sks_pkg::MODE_INSERT: begin
        if (hit) begin
          e.status = sks_pkg::ST_PRESENT;
        end else if (set_size >= CAPACITY) begin
          e.status = sks_pkg::ST_FULL;
          full_rejects++;
        end else begin
          for (i = set_size; i > pos; i--) set_keys[i] = set_keys[i - 1];
          set_keys[pos] = k;
          set_size++;
          e.status = sks_pkg::ST_OK;
        end
      end
      sks_pkg::MODE_REMOVE: begin
        if (hit) begin
          for (i = pos; i + 1 < set_size; i++) set_keys[i] = set_keys[i + 1];
          set_size--;
          e.status = sks_pkg::ST_OK;
        end else begin
          e.status = sks_pkg::ST_NOT_PRESENT;
        end
      end
      sks_pkg::MODE_COUNT: begin
        e.status = sks_pkg::ST_OK;
      end
      default: begin
        if (set_size == 0) e.status = sks_pkg::ST_EMPTY;
      end
    endcase
    e.entry_count = 5'(set_size);
    if (sks_pkg::mode_t'(r.mode) == sks_pkg::MODE_LIST && set_size > 0) begin
      n = (set_size < sks_pkg::MAX_RESULTS) ? set_size : sks_pkg::MAX_RESULTS;
      if (n > longest_list) longest_list = n;
      for (i = 0; i < n; i++) begin
        e.status = sks_pkg::ST_OK;
        e.entry_head = set_keys[i][71:8];
        e.entry_tail = set_keys[i][7:0];
        e.last = (i == n - 1);
        expected_q.push_back(e);
      end
    end else begin
      expected_q.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      set_size = 0;
      expected_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) compare_result(rsp);
      if (req_valid && !req_stall) apply_request(req);
    end
    pending = expected_q.size();
  end

endmodule

### verif/tb_sorted_unique_key_set.sv
// Testbench top for the sorted unique key set: clock, reset, request and
// response stimulus with random idling, and the verdict.
// Depends on sks_pkg, sorted_unique_key_set and sks_result_checker.
module tb_sorted_unique_key_set;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY  = 16;
  localparam int POOL_SIZE = 24;
  localparam int LONG_HOLD = 300;

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_stall;
  sks_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_stall;
  sks_pkg::rsp_t rsp;

  int fails;
  int pending;
  int checked;
  int full_rejects;
  int longest_list;

  bit tx_quiet;
  bit rx_quiet;
  bit long_hold;
  int sent_by_mode [4];
  logic [71:0] key_pool [POOL_SIZE];

  sorted_unique_key_set #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  sks_result_checker #(.CAPACITY(CAPACITY)) result_check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp),
    .fails        (fails),
    .pending      (pending),
    .checked      (checked),
    .full_rejects (full_rejects),
    .longest_list (longest_list)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin : response_side
    int w;
    rsp_stall = 1'b0;
    forever begin
      do @(posedge clk); while (!(rsp_valid && !rsp_stall));
      @(negedge clk);
      w = rx_quiet ? 0 : $urandom_range(0, 19);
      if (long_hold) begin
        w = LONG_HOLD;
        long_hold = 1'b0;
      end
      if (w > 0) begin
        rsp_stall <= 1'b1;
        repeat (w) @(negedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  task automatic send(input sks_pkg::mode_t m, input logic [71:0] k);
    int            gap;
    sks_pkg::req_t item;
    gap = tx_quiet ? 0 : $urandom_range(0, 19);
    item.mode = m;
    item.key_head = k[71:8];
    item.key_tail = k[7:0];
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent_by_mode[m]++;
  endtask

  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [71:0] related_key(input logic [71:0] base);
    logic [71:0] k;
    case ($urandom_range(0, 4))
      0:       k = {$urandom, $urandom, 8'($urandom)};
      1:       k = {base[71:16], 8'($urandom), base[7:0]};
      2:       k = {base[71:8], 8'($urandom)};
      3:       k = {base[71:40], 8'h00, 24'($urandom), 8'($urandom)};
      default: k = {8'($urandom_range(0, 3)), 56'h0, 8'($urandom)};
    endcase
    return k;
  endfunction

  task automatic run_random(input int items);
    logic [71:0]    base;
    logic [71:0]    k;
    sks_pkg::mode_t m;
    int             pick;
    base = {$urandom, $urandom, 8'($urandom)};
    foreach (key_pool[i]) key_pool[i] = related_key(base);
    repeat (items) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) m = sks_pkg::MODE_INSERT;
      else if (pick < 75) m = sks_pkg::MODE_REMOVE;
      else if (pick < 87) m = sks_pkg::MODE_COUNT;
      else m = sks_pkg::MODE_LIST;
      if ($urandom_range(0, 9) == 0) k = {$urandom, $urandom, 8'($urandom)};
      else k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      send(m, k);
    end
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    long_hold = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send(sks_pkg::MODE_LIST, '0);
    send(sks_pkg::MODE_REMOVE, '0);
    send(sks_pkg::MODE_INSERT, '0);
    send(sks_pkg::MODE_INSERT, '1);
    send(sks_pkg::MODE_INSERT, '1);
    send(sks_pkg::MODE_INSERT, {64'h4100_4200_0000_0000, 8'h00});
    send(sks_pkg::MODE_INSERT, {64'h4100_0000_0000_0000, 8'h00});
    send(sks_pkg::MODE_INSERT, {64'h4100_0000_0000_0000, 8'h01});
    send(sks_pkg::MODE_LIST, {$urandom, $urandom, 8'($urandom)});
    send(sks_pkg::MODE_REMOVE, '0);
    send(sks_pkg::MODE_COUNT, '1);
    for (int i = 0; i < CAPACITY - 4; i++) begin
      send(sks_pkg::MODE_INSERT, {8'h20 + 8'(i), $urandom, 24'($urandom), 8'($urandom)});
    end
    send(sks_pkg::MODE_INSERT, {64'h0, 8'h01});
    send(sks_pkg::MODE_INSERT, '1);
    send(sks_pkg::MODE_LIST, '0);
    send(sks_pkg::MODE_REMOVE, '1);
    send(sks_pkg::MODE_REMOVE, '1);

    run_random(20);

    long_hold = 1'b1;
    tx_quiet = 1'b1;
    run_random(15);

    drain();
    rx_quiet = 1'b1;
    run_random(20);

    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    run_random(27);

    drain();
    repeat (20) @(negedge clk);
    $display("Covered %0d inserts, %0d removes, %0d counts, %0d listings; %0d results checked.",
             sent_by_mode[sks_pkg::MODE_INSERT], sent_by_mode[sks_pkg::MODE_REMOVE],
             sent_by_mode[sks_pkg::MODE_COUNT], sent_by_mode[sks_pkg::MODE_LIST], checked);
    $display("Inserts refused on a full set: %0d, longest listing: %0d entries.",
             full_rejects, longest_list);
    if (fails == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/sks_pkg.sv
hw/rtl/sks_ctrl.sv
hw/rtl/sks_dp.sv
hw/rtl/sorted_unique_key_set.sv
verif/sks_result_checker.sv
verif/tb_sorted_unique_key_set.sv
